// ----- sv/jsv_pkg.sv -----
package jsv_pkg;

    // where the grammar stands between tokens
    typedef enum logic [2:0] {
        POS_START     = 3'd0,
        POS_ARR_ELEM  = 3'd1,
        POS_ARR_COMMA = 3'd2,
        POS_OBJ_KEY   = 3'd3,
        POS_OBJ_COLON = 3'd4,
        POS_OBJ_VALUE = 3'd5,
        POS_OBJ_COMMA = 3'd6,
        POS_END       = 3'd7
    } t_pos;

    // what the lexer is inside of
    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_STRING  = 3'd2,
        MODE_ESCAPE  = 3'd3,
        MODE_NUMBER  = 3'd4
    } t_mode;

    // scalar parse state carried from one byte to the next
    typedef struct packed {
        logic       err;
        t_pos       pos;
        t_mode      mode;
        logic       quote;   // 1 = single quote
        logic [1:0] nflags;  // bit0 digit seen, bit1 dot seen
        logic [3:0] lit;     // literal match progress, 0 = none
    } t_lex_state;

    // one stack operation per byte
    typedef struct packed {
        logic push;
        logic pop;
        logic kind;          // 1 = object, 0 = array
    } t_stack_op;

    localparam t_lex_state LEX_RESET = '{
        err:    1'b0,
        pos:    POS_START,
        mode:   MODE_NORMAL,
        quote:  1'b0,
        nflags: 2'b00,
        lit:    4'd0
    };

endpackage

// ----- sv/jsv_step.sv -----
module jsv_step #(
    parameter int MAX_NESTING = 64,
    parameter int DEPTH_W     = 7
) (
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  jsv_pkg::t_lex_state i_state,
    input  logic [DEPTH_W-1:0]  i_depth,
    input  logic                i_top,
    input  logic                i_below,
    output jsv_pkg::t_lex_state o_state,
    output logic [DEPTH_W-1:0]  o_depth,
    output jsv_pkg::t_stack_op  o_op,
    output logic                o_ok
);

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;

    localparam logic [3:0] LIT_TRUE  = 4'd1;
    localparam logic [3:0] LIT_FALSE = 4'd4;
    localparam logic [3:0] LIT_NULL  = 4'd8;

    // byte expected at each literal step: rue, alse, ull
    function automatic logic [7:0] f_lit_expect(input logic [3:0] p);
        logic [7:0] ch;
        unique case (p)
            4'd1:    ch = 8'h72;
            4'd2:    ch = 8'h75;
            4'd3:    ch = 8'h65;
            4'd4:    ch = 8'h61;
            4'd5:    ch = 8'h6C;
            4'd6:    ch = 8'h73;
            4'd7:    ch = 8'h65;
            4'd8:    ch = 8'h75;
            4'd9:    ch = 8'h6C;
            4'd10:   ch = 8'h6C;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // last step of each literal
    function automatic logic f_lit_last(input logic [3:0] p);
        return (p == 4'd3) || (p == 4'd7) || (p == 4'd10);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // a complete value moves the grammar on
    function automatic jsv_pkg::t_lex_state f_take(input jsv_pkg::t_lex_state s);
        jsv_pkg::t_lex_state r;
        r = s;
        unique case (s.pos)
            jsv_pkg::POS_START:     r.pos = jsv_pkg::POS_END;
            jsv_pkg::POS_ARR_ELEM:  r.pos = jsv_pkg::POS_ARR_COMMA;
            jsv_pkg::POS_OBJ_KEY:   r.pos = jsv_pkg::POS_OBJ_COLON;
            jsv_pkg::POS_OBJ_VALUE: r.pos = jsv_pkg::POS_OBJ_COMMA;
            default:                r.err = 1'b1;
        endcase
        return r;
    endfunction

    // close a number: needs at least one digit
    function automatic jsv_pkg::t_lex_state f_finish(input jsv_pkg::t_lex_state s);
        jsv_pkg::t_lex_state r;
        r = s;
        r.mode = jsv_pkg::MODE_NORMAL;
        if (!s.nflags[0]) begin
            r.err = 1'b1;
        end else begin
            r = f_take(r);
        end
        r.nflags = 2'b00;
        return r;
    endfunction

    jsv_pkg::t_lex_state s;
    logic [DEPTH_W-1:0]  d;
    jsv_pkg::t_stack_op  op;
    logic                run_normal;
    logic                kind;
    logic                ok;

    // mode handling, then plain token handling, then end of document
    always_comb begin
        s          = i_state;
        d          = i_depth;
        op         = '0;
        run_normal = 1'b0;
        kind       = 1'b0;
        ok         = 1'b0;

        if (!s.err) begin
            unique case (s.mode)
                jsv_pkg::MODE_COMMENT: begin
                    if (i_byte == CH_LF) begin
                        s.mode = jsv_pkg::MODE_NORMAL;
                    end
                end
                jsv_pkg::MODE_STRING: begin
                    if (i_byte == (s.quote ? CH_SQUOTE : CH_DQUOTE)) begin
                        s.mode = jsv_pkg::MODE_NORMAL;
                        s      = f_take(s);
                    end else if (i_byte == CH_BSLASH) begin
                        s.mode = jsv_pkg::MODE_ESCAPE;
                    end
                end
                jsv_pkg::MODE_ESCAPE: begin
                    s.mode = jsv_pkg::MODE_STRING;
                end
                jsv_pkg::MODE_NUMBER: begin
                    if (i_byte == CH_DOT) begin
                        if (s.nflags[1]) begin
                            s = f_finish(s);
                        end else begin
                            s.nflags[1] = 1'b1;
                        end
                    end else if (f_is_digit(i_byte)) begin
                        s.nflags[0] = 1'b1;
                    end else begin
                        s          = f_finish(s);
                        run_normal = 1'b1;
                    end
                end
                default: begin
                    if (s.lit != 4'd0 && i_byte == f_lit_expect(s.lit)) begin
                        if (f_lit_last(s.lit)) begin
                            s.lit = 4'd0;
                            s     = f_take(s);
                        end else begin
                            s.lit = s.lit + 4'd1;
                        end
                    end else begin
                        s.lit      = 4'd0;
                        s.mode     = jsv_pkg::MODE_NORMAL;
                        run_normal = 1'b1;
                    end
                end
            endcase
        end

        // token start, brackets and separators
        if (run_normal) begin
            if (i_byte == CH_HASH) begin
                s.mode = jsv_pkg::MODE_COMMENT;
            end else if (i_byte == CH_DQUOTE || i_byte == CH_SQUOTE) begin
                s.mode  = jsv_pkg::MODE_STRING;
                s.quote = (i_byte == CH_SQUOTE);
            end else if (i_byte == CH_MINUS || i_byte == CH_PLUS || i_byte == CH_DOT ||
                         f_is_digit(i_byte)) begin
                s.mode   = jsv_pkg::MODE_NUMBER;
                s.nflags = {i_byte == CH_DOT, f_is_digit(i_byte)};
            end else if (i_byte == CH_T) begin
                s.lit = LIT_TRUE;
            end else if (i_byte == CH_F) begin
                s.lit = LIT_FALSE;
            end else if (i_byte == CH_N) begin
                s.lit = LIT_NULL;
            end else if (i_byte == CH_LBRACK || i_byte == CH_LBRACE) begin
                kind = (i_byte == CH_LBRACE);
                if (s.pos == jsv_pkg::POS_START || s.pos == jsv_pkg::POS_ARR_ELEM ||
                    s.pos == jsv_pkg::POS_OBJ_VALUE) begin
                    s.pos = kind ? jsv_pkg::POS_OBJ_KEY : jsv_pkg::POS_ARR_ELEM;
                end else begin
                    s.err = 1'b1;
                end
                if (d >= DEPTH_W'(MAX_NESTING)) begin
                    s.err = 1'b1;
                end else begin
                    op.push = 1'b1;
                    op.kind = kind;
                    d       = d + DEPTH_W'(1);
                end
            end else if (i_byte == CH_RBRACK || i_byte == CH_RBRACE) begin
                kind = (i_byte == CH_RBRACE);
                if (kind ? (s.pos == jsv_pkg::POS_OBJ_KEY || s.pos == jsv_pkg::POS_OBJ_COMMA)
                         : (s.pos == jsv_pkg::POS_ARR_ELEM ||
                            s.pos == jsv_pkg::POS_ARR_COMMA)) begin
                    s.pos = kind ? jsv_pkg::POS_OBJ_KEY : jsv_pkg::POS_ARR_ELEM;
                end else begin
                    s.err = 1'b1;
                end
                if (d == DEPTH_W'(0)) begin
                    s.err = 1'b1;
                end else begin
                    op.pop = 1'b1;
                    d      = d - DEPTH_W'(1);
                    if (i_top != kind) begin
                        s.err = 1'b1;
                    end else if (d == DEPTH_W'(0)) begin
                        s.pos = jsv_pkg::POS_END;
                    end else begin
                        s.pos = i_below ? jsv_pkg::POS_OBJ_COMMA : jsv_pkg::POS_ARR_COMMA;
                    end
                end
            end else if (i_byte == CH_COMMA) begin
                if (s.pos == jsv_pkg::POS_ARR_COMMA) begin
                    s.pos = jsv_pkg::POS_ARR_ELEM;
                end else if (s.pos == jsv_pkg::POS_OBJ_COMMA) begin
                    s.pos = jsv_pkg::POS_OBJ_KEY;
                end else begin
                    s.err = 1'b1;
                end
            end else if (i_byte == CH_COLON) begin
                if (s.pos == jsv_pkg::POS_OBJ_COLON) begin
                    s.pos = jsv_pkg::POS_OBJ_VALUE;
                end else begin
                    s.err = 1'b1;
                end
            end
        end

        // end of document: close open tokens, judge, start afresh
        if (i_last) begin
            if (!s.err) begin
                if (s.mode == jsv_pkg::MODE_STRING || s.mode == jsv_pkg::MODE_ESCAPE) begin
                    s.err = 1'b1;
                end else if (s.mode == jsv_pkg::MODE_NUMBER) begin
                    s = f_finish(s);
                end
            end
            ok = !s.err && (s.pos == jsv_pkg::POS_START || s.pos == jsv_pkg::POS_END) &&
                 (d == DEPTH_W'(0));
            s  = jsv_pkg::LEX_RESET;
            d  = '0;
        end
    end

    assign o_state = s;
    assign o_depth = d;
    assign o_op    = op;
    assign o_ok    = ok;

endmodule

// ----- sv/json_stream_validator.sv -----
// JSON text checker, one byte per beat.
// Input channel: i_valid / o_ready carry i_data_byte and i_end_of_doc; the
// byte flagged with i_end_of_doc closes the document. Output channel:
// o_valid / i_ready carry o_doc_valid, one beat per document, sent after
// its final byte: 1 when the text is well formed.
// Throughput is one byte per cycle unless a final byte waits on an unread
// verdict. A byte is held in the input register, parsed by the step logic,
// and its verdict lands in the result register: a document's result is
// shown once its final byte has left the input register, unless an earlier
// verdict is still waiting. The nesting shift stack holds MAX_NESTING + 1
// bits, one push or pop per byte, with the top two bits read directly.
// While a result waits unread, bytes that do not end a document keep
// flowing; a further final byte waits in the input register, and only then
// does o_ready fall.
// Reset (synchronous, active low) empties both registers and returns the
// parser to the start of a document; the stack contents need no clearing.
module json_stream_validator #(
    parameter int MAX_NESTING = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_end_of_doc,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_doc_valid
);

    localparam int DEPTH_W = $clog2(MAX_NESTING + 1);

    logic                r_in_valid;
    logic [7:0]          r_byte;
    logic                r_last;
    jsv_pkg::t_lex_state r_state;
    logic [DEPTH_W-1:0]  r_depth;
    logic [MAX_NESTING:0] r_stack;
    logic                r_out_valid;
    logic                r_doc_valid;

    jsv_pkg::t_lex_state n_state;
    logic [DEPTH_W-1:0]  n_depth;
    jsv_pkg::t_stack_op  w_op;
    logic                w_ok;
    logic                w_adv;

    // a byte moves on unless it carries a verdict with nowhere to go
    assign w_adv   = r_in_valid && (!r_last || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_byte <= i_data_byte;
            r_last <= i_end_of_doc;
        end
    end

    jsv_step #(
        .MAX_NESTING(MAX_NESTING),
        .DEPTH_W    (DEPTH_W)
    ) u_step (
        .i_byte (r_byte),
        .i_last (r_last),
        .i_state(r_state),
        .i_depth(r_depth),
        .i_top  (r_stack[0]),
        .i_below(r_stack[1]),
        .o_state(n_state),
        .o_depth(n_depth),
        .o_op   (w_op),
        .o_ok   (w_ok)
    );

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jsv_pkg::LEX_RESET;
            r_depth <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
            r_depth <= n_depth;
        end
    end

    // nesting stack, top of stack at bit 0
    always_ff @(posedge i_clk) begin
        if (w_adv && w_op.push) begin
            r_stack <= {r_stack[MAX_NESTING-1:0], w_op.kind};
        end else if (w_adv && w_op.pop) begin
            r_stack <= {1'b0, r_stack[MAX_NESTING:1]};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_last) begin
            r_doc_valid <= w_ok;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_doc_valid = r_doc_valid;

endmodule

// ----- sv/jsv_checker.sv -----
module jsv_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       i_end_of_doc,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_doc_valid
);

    logic       w_in_beat;
    logic       w_out_beat;
    logic [1:0] r_pending;

    assign w_in_beat  = i_valid && o_ready;
    assign w_out_beat = o_valid && i_ready;

    // final bytes taken whose verdict is not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
        end else begin
            r_pending <= r_pending + 2'(w_in_beat && i_end_of_doc) - 2'(w_out_beat);
        end
    end

    // a stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_doc_valid))
        else $error("verdict changed or dropped while stalled");

    // no verdict without a final byte behind it
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_pending != 2'd0)
        else $error("verdict without a final byte");

    // at most one verdict in each of the two registers
    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending != 2'd3)
        else $error("too many documents in flight");

    // with the result register empty the input side never stalls
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with no verdict waiting");

endmodule

bind json_stream_validator jsv_checker u_jsv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_end_of_doc(i_end_of_doc),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_doc_valid (o_doc_valid)
);

// ----- tb/tb_top.sv -----
module tb_top;

    localparam int          NEST_MAX       = 64;
    localparam int          RAND_BYTES     = 1950;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int unsigned LIT_NONE       = 0;
    localparam int unsigned LIT_T          = 1;
    localparam int unsigned LIT_F          = 4;
    localparam int unsigned LIT_N          = 8;
    localparam int unsigned LIT_LAST       = 10;
    localparam logic [1:0]  NF_DIGIT       = 2'b01;
    localparam logic [1:0]  NF_DOT         = 2'b10;

    // parse-state model of the validator and the verdicts still owed
    class t_verdict_board;
        jsv_pkg::t_pos  pos;
        bit             kinds[NEST_MAX];
        int unsigned    depth;
        bit             err;
        jsv_pkg::t_mode mode;
        bit             quote;
        logic [1:0]     nflags;
        int unsigned    lit;
        string          lit_tail = "-ruealseull";
        bit             verdicts_due[$];
        int             fails;

        function new();
            fails = 0;
            clear_doc();
        endfunction

        function void clear_doc();
            pos    = jsv_pkg::POS_START;
            depth  = 0;
            err    = 1'b0;
            mode   = jsv_pkg::MODE_NORMAL;
            quote  = 1'b0;
            nflags = '0;
            lit    = LIT_NONE;
        endfunction

        // a complete value moves the grammar on
        function void take_value();
            case (pos)
                jsv_pkg::POS_START:     pos = jsv_pkg::POS_END;
                jsv_pkg::POS_ARR_ELEM:  pos = jsv_pkg::POS_ARR_COMMA;
                jsv_pkg::POS_OBJ_KEY:   pos = jsv_pkg::POS_OBJ_COLON;
                jsv_pkg::POS_OBJ_VALUE: pos = jsv_pkg::POS_OBJ_COMMA;
                default:                err = 1'b1;
            endcase
        endfunction

        function void end_number();
            mode = jsv_pkg::MODE_NORMAL;
            if ((nflags & NF_DIGIT) == '0) err = 1'b1;
            else take_value();
            nflags = '0;
        endfunction

        function void open_level(bit is_obj);
            if (pos == jsv_pkg::POS_START || pos == jsv_pkg::POS_ARR_ELEM ||
                pos == jsv_pkg::POS_OBJ_VALUE) begin
                if (is_obj) pos = jsv_pkg::POS_OBJ_KEY;
                else pos = jsv_pkg::POS_ARR_ELEM;
            end else begin
                err = 1'b1;
            end
            // overflow
            if (depth >= NEST_MAX) begin
                err = 1'b1;
                return;
            end
            kinds[depth] = is_obj;
            depth++;
        endfunction

        function void close_level(bit is_obj);
            jsv_pkg::t_pos open_pos;
            jsv_pkg::t_pos comma_pos;
            if (is_obj) begin
                open_pos  = jsv_pkg::POS_OBJ_KEY;
                comma_pos = jsv_pkg::POS_OBJ_COMMA;
            end else begin
                open_pos  = jsv_pkg::POS_ARR_ELEM;
                comma_pos = jsv_pkg::POS_ARR_COMMA;
            end
            if (pos == open_pos || pos == comma_pos) pos = open_pos;
            else err = 1'b1;
            // underflow
            if (depth == 0) begin
                err = 1'b1;
                return;
            end
            depth--;
            // closer of the wrong kind
            if (kinds[depth] != is_obj) begin
                err = 1'b1;
                return;
            end
            if (depth == 0) pos = jsv_pkg::POS_END;
            else if (kinds[depth - 1]) pos = jsv_pkg::POS_OBJ_COMMA;
            else pos = jsv_pkg::POS_ARR_COMMA;
        endfunction

        // byte seen outside any token
        function void plain_byte(logic [7:0] c);
            if (c == "#") begin
                mode = jsv_pkg::MODE_COMMENT;
            end else if (c == "\"" || c == "'") begin
                mode  = jsv_pkg::MODE_STRING;
                quote = (c == "'");
            end else if (c == "-" || c == "+" || c == "." || (c >= "0" && c <= "9")) begin
                mode = jsv_pkg::MODE_NUMBER;
                if (c == ".") nflags = NF_DOT;
                else if (c >= "0" && c <= "9") nflags = NF_DIGIT;
                else nflags = '0;
            end else if (c == "t") begin
                lit = LIT_T;
            end else if (c == "f") begin
                lit = LIT_F;
            end else if (c == "n") begin
                lit = LIT_N;
            end else if (c == "[") begin
                open_level(1'b0);
            end else if (c == "{") begin
                open_level(1'b1);
            end else if (c == "]") begin
                close_level(1'b0);
            end else if (c == "}") begin
                close_level(1'b1);
            end else if (c == ",") begin
                if (pos == jsv_pkg::POS_ARR_COMMA) pos = jsv_pkg::POS_ARR_ELEM;
                else if (pos == jsv_pkg::POS_OBJ_COMMA) pos = jsv_pkg::POS_OBJ_KEY;
                else err = 1'b1;
            end else if (c == ":") begin
                if (pos == jsv_pkg::POS_OBJ_COLON) pos = jsv_pkg::POS_OBJ_VALUE;
                else err = 1'b1;
            end
        endfunction

        function void lex_byte(logic [7:0] c);
            case (mode)
                jsv_pkg::MODE_COMMENT: begin
                    if (c == "\n") mode = jsv_pkg::MODE_NORMAL;
                end
                jsv_pkg::MODE_STRING: begin
                    if ((quote && c == "'") || (!quote && c == "\"")) begin
                        mode = jsv_pkg::MODE_NORMAL;
                        take_value();
                    end else if (c == "\\") begin
                        mode = jsv_pkg::MODE_ESCAPE;
                    end
                end
                jsv_pkg::MODE_ESCAPE: mode = jsv_pkg::MODE_STRING;
                jsv_pkg::MODE_NUMBER: begin
                    // a second dot closes the number and is swallowed
                    if (c == ".") begin
                        if ((nflags & NF_DOT) != '0) end_number();
                        else nflags = nflags | NF_DOT;
                    end else if (c >= "0" && c <= "9") begin
                        nflags = nflags | NF_DIGIT;
                    end else begin
                        end_number();
                        plain_byte(c);
                    end
                end
                default: begin
                    // literal matching, a broken literal is dropped
                    if (lit != LIT_NONE && lit <= LIT_LAST && c == lit_tail[lit]) begin
                        if (lit == LIT_F - 1 || lit == LIT_N - 1 || lit == LIT_LAST) begin
                            lit = LIT_NONE;
                            take_value();
                        end else begin
                            lit++;
                        end
                    end else begin
                        lit  = LIT_NONE;
                        mode = jsv_pkg::MODE_NORMAL;
                        plain_byte(c);
                    end
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] c, logic last);
            bit ok;
            if (!err) lex_byte(c);
            if (!last) return;
            // close out the document
            if (!err) begin
                if (mode == jsv_pkg::MODE_STRING || mode == jsv_pkg::MODE_ESCAPE) err = 1'b1;
                else if (mode == jsv_pkg::MODE_NUMBER) end_number();
            end
            ok = !err && (pos == jsv_pkg::POS_START || pos == jsv_pkg::POS_END) &&
                 depth == 0;
            verdicts_due.push_back(ok);
            clear_doc();
        endfunction

        function void check_verdict(logic got);
            bit want;
            if (verdicts_due.size() == 0) begin
                $display("%0t: stray verdict beat, expected none, got %0b", $time, got);
                fails++;
                return;
            end
            want = verdicts_due.pop_front();
            if (got !== want) begin
                $display("%0t: doc_valid mismatch, expected %0b, got %0b", $time, want, got);
                fails++;
            end
        endfunction
    endclass

    typedef enum {G_VALUE, G_FIRST, G_AFTER, G_CLOSE, G_DONE} t_gen_step;

    logic        i_clk     = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  in_data   = '0;
    logic        in_eod    = 1'b0;
    logic        out_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_doc_valid;

    t_verdict_board sb = new();
    logic [7:0]     doc_q[$];
    int unsigned    send_idle_pct  = 0;
    int unsigned    recv_stall_pct = 0;
    int             bytes_sent     = 0;
    int             idle_cycles    = 0;

    json_stream_validator #(
        .MAX_NESTING(NEST_MAX)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_ready     (o_ready),
        .i_data_byte (in_data),
        .i_end_of_doc(in_eod),
        .o_valid     (o_valid),
        .i_ready     (out_ready),
        .o_doc_valid (o_doc_valid)
    );

    always #5 i_clk = ~i_clk;

    // one input beat, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        in_eod   <= last;
        do @(posedge i_clk); while (!o_ready);
        sb.note_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_doc();
        for (int i = 0; i < doc_q.size(); i++) send_byte(doc_q[i], i == doc_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        doc_q.delete();
        for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
        send_doc();
    endtask

    // hold the sender back until every verdict is in
    task automatic drain_verdicts();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.verdicts_due.size() != 0);
    endtask

    function automatic logic [7:0] byte_but(logic [7:0] x, logic [7:0] y);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == x || b == y);
        return b;
    endfunction

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++) doc_q.push_back(s[i]);
    endtask

    // whitespace or a comment between tokens
    task automatic put_ws();
        int n;
        case ($urandom_range(0, 9))
            0: doc_q.push_back(" ");
            1: doc_q.push_back("\n");
            2: doc_q.push_back("\t");
            3: begin
                doc_q.push_back("#");
                n = $urandom_range(0, 5);
                repeat (n) doc_q.push_back(byte_but("\n", "\n"));
                doc_q.push_back("\n");
            end
            default: ;
        endcase
    endtask

    // number, string or literal
    task automatic put_scalar();
        int         n;
        int         dot_at;
        logic [7:0] q;
        case ($urandom_range(0, 2))
            0: begin
                if ($urandom_range(0, 1) == 1) begin
                    if ($urandom_range(0, 1) == 1) doc_q.push_back("-");
                    else doc_q.push_back("+");
                end
                n      = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
                dot_at = ($urandom_range(0, 2) == 0) ? $urandom_range(0, n) : -1;
                for (int i = 0; i <= n; i++) begin
                    if (i == dot_at) doc_q.push_back(".");
                    if (i < n) doc_q.push_back(8'("0" + $urandom_range(0, 9)));
                end
            end
            1: begin
                q = ($urandom_range(0, 1) == 1) ? 8'("'") : 8'("\"");
                doc_q.push_back(q);
                n = $urandom_range(0, 6);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        doc_q.push_back("\\");
                        doc_q.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        doc_q.push_back(byte_but(q, "\\"));
                    end
                end
                doc_q.push_back(q);
            end
            default: begin
                case ($urandom_range(0, 2))
                    0: put_text("true");
                    1: put_text("false");
                    default: put_text("null");
                endcase
            end
        endcase
    endtask

    task automatic put_key();
        put_scalar();
        put_ws();
        doc_q.push_back(":");
    endtask

    // generated document, not always well formed; deep_target above zero nests straight down to it
    task automatic build_doc(input int deep_target);
        bit        open_kinds[NEST_MAX + 2];
        int        gd;
        int        budget;
        int        max_d;
        bit        k;
        t_gen_step st;
        doc_q.delete();
        gd     = 0;
        st     = G_VALUE;
        budget = (deep_target > 0) ? 0 : $urandom_range(0, 10);
        max_d  = (deep_target > 0) ? deep_target : $urandom_range(1, 4);
        while (st != G_DONE) begin
            if (deep_target == 0) put_ws();
            case (st)
                G_VALUE: begin
                    if (gd < max_d && (deep_target > 0 ||
                                       (budget > 0 && $urandom_range(0, 2) == 0))) begin
                        if (deep_target > 0) k = ($urandom_range(0, 7) == 0);
                        else k = 1'($urandom_range(0, 1));
                        doc_q.push_back(k ? 8'("{") : 8'("["));
                        open_kinds[gd] = k;
                        gd++;
                        if (budget > 0) budget--;
                        st = G_FIRST;
                    end else begin
                        put_scalar();
                        st = G_AFTER;
                    end
                end
                G_FIRST: begin
                    if (deep_target == 0 && $urandom_range(0, 4) == 0) begin
                        st = G_CLOSE;
                    end else begin
                        if (open_kinds[gd - 1]) put_key();
                        st = G_VALUE;
                    end
                end
                G_AFTER: begin
                    if (gd == 0) begin
                        st = G_DONE;
                    end else if (budget > 0 && $urandom_range(0, 2) != 0) begin
                        doc_q.push_back(",");
                        budget--;
                        if (open_kinds[gd - 1]) put_key();
                        st = G_VALUE;
                    end else begin
                        // trailing comma now and then
                        if ($urandom_range(0, 9) == 0) doc_q.push_back(",");
                        st = G_CLOSE;
                    end
                end
                default: begin
                    gd--;
                    doc_q.push_back(open_kinds[gd] ? 8'("}") : 8'("]"));
                    st = G_AFTER;
                end
            endcase
        end
    endtask

    // verdict channel with random back-pressure
    always @(posedge i_clk) begin
        if (rst_n && o_valid && out_ready) sb.check_verdict(o_doc_valid);
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // watchdog on cycles without any beat
    always @(posedge i_clk) begin
        if (!rst_n || (in_valid && o_ready) || (o_valid && out_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int base;
        int doc_no;
        int n;
        int p;
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // directed documents
        send_text("[1.2.,]");
        send_text("{5:'\\'x'}");
        send_text("-]");
        send_text("nul");
        send_text("[}");
        send_text("#\n]");
        send_byte("\"", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b1);

        // random documents over four idling phases
        base   = bytes_sent;
        doc_no = 0;
        for (int ph = 0; ph < 4; ph++) begin
            drain_verdicts();
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            while (bytes_sent < base + (ph + 1) * RAND_BYTES / 4) begin
                doc_no++;
                if (doc_no % 30 == 0) begin
                    // full depth, or one level past it
                    build_doc(((doc_no / 30) % 2 == 1) ? NEST_MAX : NEST_MAX + 1);
                end else if ($urandom_range(0, 11) == 0) begin
                    doc_q.delete();
                    n = $urandom_range(1, 12);
                    repeat (n) doc_q.push_back(8'($urandom_range(0, 255)));
                end else begin
                    build_doc(0);
                    // damage some documents
                    if (doc_q.size() > 0 && $urandom_range(0, 3) == 0) begin
                        p = $urandom_range(0, doc_q.size() - 1);
                        case ($urandom_range(0, 4))
                            0: doc_q[p] = 8'($urandom_range(0, 255));
                            1: if (doc_q.size() > 1) doc_q.delete(p);
                            2: doc_q.insert(p, 8'($urandom_range(0, 255)));
                            3: while (doc_q.size() > p + 1) void'(doc_q.pop_back());
                            default: doc_q.push_front("]");
                        endcase
                    end
                end
                send_doc();
            end
        end

        // wind down
        in_valid <= 1'b0;
        while (sb.verdicts_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.fails == 0 && sb.verdicts_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- json_stream_validator.f -----
sv/jsv_pkg.sv
sv/jsv_step.sv
sv/json_stream_validator.sv
sv/jsv_checker.sv
tb/tb_top.sv
